// ===== src/gbr_pkg.sv =====
// Shared types, command codes and helpers for the glyph bitmap rasterizer.
// No dependencies; every other file in src imports this package.
package gbr_pkg;

    // Command codes carried on the input tuser
    localparam logic [1:0] CMD_LOAD_BITMAP = 2'd0;
    localparam logic [1:0] CMD_LOAD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_SET_CURSOR  = 2'd2;
    localparam logic [1:0] CMD_DRAW_CHAR   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FIRST_CODE = 2'd0;
    localparam logic [1:0] REG_LAST_CODE  = 2'd1;
    localparam logic [1:0] REG_PEN_COLOR  = 2'd2;

    localparam logic [7:0] FIRST_CODE_RST = 8'd32;
    localparam logic [7:0] LAST_CODE_RST  = 8'd126;
    localparam logic [2:0] PEN_COLOR_RST  = 3'd7;

    // Rows per glyph never exceed the output mask count
    localparam int ROW_LIMIT = 32;

    typedef struct packed {
        logic [7:0]        x_advance;
        logic signed [7:0] y_offset;
        logic signed [7:0] x_offset;
        logic [5:0]        glyph_height;
        logic [5:0]        glyph_width;
        logic [11:0]       glyph_offset;
    } gbr_glyph_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic latch;     // glyph record is on the table read register
        logic reduce;    // wrap start address into the store
        logic fetch;     // read first bitmap byte
        logic finish;    // zero-row glyph: advance cursor, emit empty result
        logic step;      // consume one byte segment of the current row
    } gbr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic draw_ok;   // input item is a drawable character
        logic addr_high; // start address still beyond the store
        logic h_zero;    // glyph has no rows
        logic row_done;  // current segment completes the row
        logic last_row;  // current row is the final one
        logic out_free;  // output register can take a result
    } gbr_status_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/gbr_ctrl.sv =====
// Sequencer for the glyph bitmap rasterizer: accept, lookup, address wrap,
// row walk. Depends on gbr_pkg; drives gbr_datapath through gbr_cmd_t.
module gbr_ctrl
    import gbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  gbr_status_t st,
    output gbr_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_REDUCE = 2'd2;
    localparam logic [1:0] S_ROW    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = st.out_free;
                cmd.accept = s_tvalid && st.out_free;
                if (cmd.accept && st.draw_ok) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.latch  = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                priority if (st.addr_high) begin
                    cmd.reduce = 1'b1;
                end else if (st.h_zero) begin
                    // hold until the output register frees up
                    if (st.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                cmd.step = !st.row_done || st.out_free;
                if (cmd.step && st.row_done && st.last_row) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_draw_enters_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && st.draw_ok) |=> state_reg == S_LOOKUP)
        else $error("drawable character did not start a lookup");

endmodule

// ===== src/gbr_datapath.sv =====
// Datapath of the glyph bitmap rasterizer: bitmap store, glyph table, cursor,
// configuration registers, row mask builder and output register. Uses gbr_pkg.
module gbr_datapath
    import gbr_pkg::*;
#(
    parameter int BITMAP_BYTES  = 4096,
    parameter int GLYPH_ENTRIES = 256,
    parameter int MAX_GLYPH_W   = 32,
    parameter int MAX_GLYPH_H   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic [1:0]         command,
    input  logic [11:0]        table_index,
    input  logic [7:0]         data_byte,
    input  gbr_glyph_t         glyph_rec,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [7:0]         char_code,
    input  gbr_cmd_t           cmd,
    output gbr_status_t        st,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [15:0] row_x,
    output logic signed [15:0] row_y,
    output logic [31:0]        row_mask,
    output logic [2:0]         color,
    output logic signed [15:0] cursor_after,
    output logic               drawn,
    output logic               last
);

    localparam int AW     = $clog2(BITMAP_BYTES);
    localparam int ADDR_W = (AW > 12) ? AW : 12;
    localparam int GW     = $clog2(GLYPH_ENTRIES);
    localparam int WCW    = $clog2(MAX_GLYPH_W + 1);
    localparam int MW     = MAX_GLYPH_W;
    localparam int OW     = (MW < 32) ? MW : 32;
    localparam int HLIM   = (MAX_GLYPH_H < ROW_LIMIT) ? MAX_GLYPH_H : ROW_LIMIT;

    logic [7:0]       bitmap_mem [BITMAP_BYTES];
    gbr_glyph_t       glyph_mem  [GLYPH_ENTRIES];

    logic [7:0]         first_code_reg, last_code_reg;
    logic [2:0]         pen_color_reg;
    logic signed [15:0] cursor_x_reg, cursor_x_next;
    logic signed [15:0] cursor_y_reg, cursor_y_next;

    gbr_glyph_t         glyph_rd_reg;
    logic [7:0]         byte_rd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [2:0]         bib_reg;
    logic [WCW-1:0]     col_reg;
    logic [WCW-1:0]     wlim_reg;
    logic [5:0]         row_reg;
    logic [5:0]         hlim_reg;
    logic [MW-1:0]      mask_reg;
    logic signed [15:0] rx_reg;
    logic signed [17:0] ybase_reg;
    logic signed [15:0] cur_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    logic signed [15:0] row_x_reg, row_y_reg, cursor_after_reg;
    logic [31:0]        row_mask_reg;
    logic [2:0]         color_reg;
    logic               drawn_reg, last_reg;

    logic [7:0]         code_diff;
    logic               draw_ok;
    logic               bm_wr_en, gl_wr_en;
    logic [ADDR_W-1:0]  idx_ext;
    logic [ADDR_W-1:0]  addr_inc;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [3:0]         avail, k;
    logic [WCW-1:0]     rem;
    logic               row_done, byte_exh, last_row;
    logic [7:0]         rev, seg, k_mask;
    logic [MW+7:0]      seg_wide;
    logic [MW-1:0]      mask_new;
    logic               emit_row, emit_empty;

    assign code_diff = char_code - first_code_reg;
    assign draw_ok   = (command == CMD_DRAW_CHAR) && (char_code >= first_code_reg)
                       && (char_code <= last_code_reg)
                       && (32'(code_diff) < GLYPH_ENTRIES);
    assign bm_wr_en  = cmd.accept && (command == CMD_LOAD_BITMAP)
                       && (32'(table_index) < BITMAP_BYTES);
    assign gl_wr_en  = cmd.accept && (command == CMD_LOAD_GLYPH)
                       && (32'(table_index) < GLYPH_ENTRIES);
    assign idx_ext   = ADDR_W'(table_index);
    assign addr_inc  = (32'(addr_reg) == BITMAP_BYTES - 1) ? '0 : addr_reg + 1'b1;

    // Segment of the current byte that falls in the current row
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            rev[j] = byte_rd_reg[7-j];
        end
        avail = 4'd8 - {1'b0, bib_reg};
        rem   = wlim_reg - col_reg;
        k     = (32'(rem) < 32'(avail)) ? 4'(rem) : avail;
        k_mask   = 8'((9'd1 << k) - 9'd1);
        seg      = (rev >> bib_reg) & k_mask;
        seg_wide = (MW+8)'(seg) << col_reg;
        mask_new = mask_reg | seg_wide[MW-1:0];
        row_done = ({1'b0, col_reg} + (WCW+1)'(k)) == {1'b0, wlim_reg};
        byte_exh = ({1'b0, bib_reg} + k) == 4'd8;
        last_row = ({1'b0, row_reg} + 7'd1) == {1'b0, hlim_reg};
    end

    assign st.draw_ok   = draw_ok;
    assign st.addr_high = 32'(addr_reg) >= BITMAP_BYTES;
    assign st.h_zero    = (hlim_reg == 6'd0);
    assign st.row_done  = row_done;
    assign st.last_row  = last_row;
    assign st.out_free  = !m_tvalid_reg || m_tready;

    assign rd_en   = cmd.fetch || (cmd.step && byte_exh);
    assign rd_addr = cmd.fetch ? addr_reg : addr_inc;

    always_ff @(posedge aclk) begin
        if (bm_wr_en) begin
            bitmap_mem[idx_ext[AW-1:0]] <= data_byte;
        end
        if (rd_en) begin
            byte_rd_reg <= bitmap_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (gl_wr_en) begin
            glyph_mem[table_index[GW-1:0]] <= glyph_rec;
        end
        if (cmd.accept && draw_ok) begin
            glyph_rd_reg <= glyph_mem[code_diff[GW-1:0]];
        end
    end

    // Glyph walk registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            rx_reg    <= sat16({{2{cursor_x_reg[15]}}, cursor_x_reg}
                               + {{10{glyph_rd_reg.x_offset[7]}}, glyph_rd_reg.x_offset});
            cur_reg   <= sat16({{2{cursor_x_reg[15]}}, cursor_x_reg}
                               + {10'd0, glyph_rd_reg.x_advance});
            ybase_reg <= {{2{cursor_y_reg[15]}}, cursor_y_reg}
                         - {{10{glyph_rd_reg.y_offset[7]}}, glyph_rd_reg.y_offset};
            wlim_reg  <= (32'(glyph_rd_reg.glyph_width) > MAX_GLYPH_W)
                         ? WCW'(MAX_GLYPH_W) : WCW'(glyph_rd_reg.glyph_width);
            hlim_reg  <= (32'(glyph_rd_reg.glyph_height) > HLIM)
                         ? 6'(HLIM) : glyph_rd_reg.glyph_height;
            addr_reg  <= ADDR_W'(glyph_rd_reg.glyph_offset);
            bib_reg   <= '0;
            col_reg   <= '0;
            mask_reg  <= '0;
            row_reg   <= '0;
        end else if (cmd.reduce) begin
            addr_reg <= addr_reg - ADDR_W'(BITMAP_BYTES);
        end else if (cmd.step) begin
            bib_reg <= bib_reg + k[2:0];
            if (byte_exh) begin
                addr_reg <= addr_inc;
            end
            if (row_done) begin
                col_reg  <= '0;
                mask_reg <= '0;
                row_reg  <= row_reg + 6'd1;
            end else begin
                col_reg  <= col_reg + WCW'(k);
                mask_reg <= mask_new;
            end
        end
    end

    // Cursor and configuration
    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.accept && (command == CMD_SET_CURSOR)) begin
            cursor_x_next = pos_x;
            cursor_y_next = pos_y;
        end else if (cmd.finish || (cmd.step && row_done && last_row)) begin
            cursor_x_next = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_code_reg <= FIRST_CODE_RST;
            last_code_reg  <= LAST_CODE_RST;
            pen_color_reg  <= PEN_COLOR_RST;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FIRST_CODE: first_code_reg <= cfg_wdata;
                    REG_LAST_CODE:  last_code_reg  <= cfg_wdata;
                    REG_PEN_COLOR:  pen_color_reg  <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    // Output register
    assign emit_row      = cmd.step && row_done;
    assign emit_empty    = (cmd.accept && !draw_ok) || cmd.finish;
    assign m_tvalid_next = emit_row || emit_empty || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_row) begin
            row_x_reg        <= rx_reg;
            row_y_reg        <= sat16(ybase_reg - {12'd0, row_reg});
            row_mask_reg     <= 32'(mask_new[OW-1:0]);
            color_reg        <= pen_color_reg;
            cursor_after_reg <= cur_reg;
            drawn_reg        <= 1'b1;
            last_reg         <= last_row;
        end else if (emit_empty) begin
            row_x_reg        <= '0;
            row_y_reg        <= '0;
            row_mask_reg     <= '0;
            color_reg        <= '0;
            cursor_after_reg <= cursor_x_next;
            drawn_reg        <= 1'b0;
            last_reg         <= 1'b1;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign row_x        = row_x_reg;
    assign row_y        = row_y_reg;
    assign row_mask     = row_mask_reg;
    assign color        = color_reg;
    assign cursor_after = cursor_after_reg;
    assign drawn        = drawn_reg;
    assign last         = last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_row || emit_empty) |-> st.out_free)
        else $error("result loaded over a pending transfer");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_row |=> m_tvalid_reg && drawn_reg)
        else $error("row result not presented");

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> col_reg <= wlim_reg)
        else $error("column walked past glyph width");

    a_cursor_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept || cmd.finish || cmd.step) |=> $stable(cursor_x_reg))
        else $error("cursor moved without a command");

endmodule

// ===== src/glyph_bitmap_rasterizer_top.sv =====
// Top level of the glyph bitmap rasterizer: stream ports, field packing,
// controller and datapath. Depends on gbr_pkg, gbr_ctrl and gbr_datapath.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata (record fields), s_tuser (command)
//  m_        out        m_tvalid/m_tready  m_tdata (row result), m_tuser (drawn), m_tlast
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// Load and set-cursor commands, and draws with no glyph, finish on acceptance.
// A draw steps through the lookup, one address reduction per whole BITMAP_BYTES
// of start offset beyond the store, the first byte fetch and then one step per
// bitmap byte segment of each row: at most ceil(width/8) + 1 segments a row, and
// ceil(width/8) for a 32x32 glyph, since its rows stay byte aligned. The single
// read port of the bitmap store reads one byte a cycle while the walk is not held.
// Reset is synchronous on aresetn low and clears cursor, configuration registers and control.
// A result that is not taken holds the row walk at the next row end only.
module glyph_bitmap_rasterizer_top
    import gbr_pkg::*;
#(
    parameter int BITMAP_BYTES  = 4096,
    parameter int GLYPH_ENTRIES = 256,
    parameter int MAX_GLYPH_W   = 32,
    parameter int MAX_GLYPH_H   = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_index, data_byte, glyph_offset, glyph_width, glyph_height,
    // x_offset, y_offset, x_advance, pos_x, pos_y, char_code
    input  logic [111:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_x, row_y, row_mask, color, cursor_after
    output logic [87:0]  m_tdata,
    // drawn
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    gbr_cmd_t           cmd;
    gbr_status_t        st;
    gbr_glyph_t         glyph_rec;
    logic signed [15:0] row_x, row_y, cursor_after;
    logic [31:0]        row_mask;
    logic [2:0]         color;
    logic               drawn;

    assign glyph_rec.glyph_offset = s_tdata[31:20];
    assign glyph_rec.glyph_width  = s_tdata[37:32];
    assign glyph_rec.glyph_height = s_tdata[43:38];
    assign glyph_rec.x_offset     = s_tdata[51:44];
    assign glyph_rec.y_offset     = s_tdata[59:52];
    assign glyph_rec.x_advance    = s_tdata[67:60];

    gbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gbr_datapath #(
        .BITMAP_BYTES  (BITMAP_BYTES),
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .MAX_GLYPH_W   (MAX_GLYPH_W),
        .MAX_GLYPH_H   (MAX_GLYPH_H)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .command      (s_tuser),
        .table_index  (s_tdata[11:0]),
        .data_byte    (s_tdata[19:12]),
        .glyph_rec    (glyph_rec),
        .pos_x        (s_tdata[83:68]),
        .pos_y        (s_tdata[99:84]),
        .char_code    (s_tdata[107:100]),
        .cmd          (cmd),
        .st           (st),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .row_x        (row_x),
        .row_y        (row_y),
        .row_mask     (row_mask),
        .color        (color),
        .cursor_after (cursor_after),
        .drawn        (drawn),
        .last         (m_tlast)
    );

    assign m_tdata = {5'd0, cursor_after, color, row_mask, row_y, row_x};
    assign m_tuser = drawn;

endmodule
